// File: hdl/spq_pkg.sv
// Shared constants and types for the stable priority task queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;
  localparam int PRIO_W          = 3;
  localparam int OCC_W           = 5;
  localparam logic [PRIO_W-1:0] MAX_PRIORITY = 3'd5;

  typedef enum logic [1:0] {
    OC_SUBMITTED = 2'd0,
    OC_DROPPED   = 2'd1,
    OC_DEQUEUED  = 2'd2,
    OC_EMPTY     = 2'd3
  } outcome_t;

endpackage

// File: hdl/spq_ram.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module spq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 19,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/spq_ctrl.sv
// Queue sequencer: ring pointers, sorted-insert walk, dequeue and result register.
`timescale 1ns / 1ps
module spq_ctrl #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF,
  localparam int IDX_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int ENT_W = TAG_BITS + spq_pkg::PRIO_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [TAG_BITS-1:0]        in_tag,
  input  logic [spq_pkg::PRIO_W-1:0] in_prio,
  output logic                       out_valid,
  input  logic                       out_ready,
  output spq_pkg::outcome_t          out_outcome,
  output logic [TAG_BITS-1:0]        out_tag,
  output logic [spq_pkg::PRIO_W-1:0] out_prio,
  output logic [spq_pkg::OCC_W-1:0]  out_occ,
  output logic                       mem_we,
  output logic [IDX_W-1:0]           mem_waddr,
  output logic [ENT_W-1:0]           mem_wdata,
  output logic [IDX_W-1:0]           mem_raddr,
  input  logic [ENT_W-1:0]           mem_rdata
);

  localparam logic [IDX_W:0]   DEPTH_W = (IDX_W+1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(QUEUE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_PLACE = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           cur_r, cur_nxt;
  logic [TAG_BITS-1:0]        new_tag_r, new_tag_nxt;
  logic [spq_pkg::PRIO_W-1:0] new_prio_r, new_prio_nxt;
  logic                       out_valid_r, out_valid_nxt;
  spq_pkg::outcome_t          outcome_r, outcome_nxt;
  logic [TAG_BITS-1:0]        otag_r, otag_nxt;
  logic [spq_pkg::PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [spq_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  logic [spq_pkg::PRIO_W-1:0] sat_prio;
  logic [spq_pkg::PRIO_W-1:0] rd_prio;
  logic                       accept;
  logic                       done;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign sat_prio = (in_prio > spq_pkg::MAX_PRIORITY) ? spq_pkg::MAX_PRIORITY : in_prio;
  assign rd_prio  = mem_rdata[ENT_W-1 -: spq_pkg::PRIO_W];
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    new_tag_nxt  = new_tag_r;
    new_prio_nxt = new_prio_r;
    outcome_nxt  = outcome_r;
    otag_nxt     = otag_r;
    oprio_nxt    = oprio_r;
    done         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = phys(head_r, cur_r + IDX_W'(1));
    mem_wdata    = {new_prio_r, new_tag_r};
    mem_raddr    = phys(head_r, cur_r - IDX_W'(1));

    case (state_r)
      ST_IDLE: begin
        mem_raddr = head_r;
        if (accept) begin
          otag_nxt  = '0;
          oprio_nxt = '0;
          if (!in_cmd) begin
            if (count_r == FULL_C) begin
              outcome_nxt = spq_pkg::OC_DROPPED;
              done        = 1'b1;
            end else if (count_r == '0) begin
              mem_we      = 1'b1;
              mem_waddr   = head_r;
              mem_wdata   = {sat_prio, in_tag};
              count_nxt   = count_r + CNT_W'(1);
              outcome_nxt = spq_pkg::OC_SUBMITTED;
              done        = 1'b1;
            end else begin
              cur_nxt      = count_r[IDX_W-1:0] - IDX_W'(1);
              mem_raddr    = phys(head_r, cur_nxt);
              new_tag_nxt  = in_tag;
              new_prio_nxt = sat_prio;
              state_nxt    = ST_WALK;
            end
          end else begin
            if (count_r == '0) begin
              outcome_nxt = spq_pkg::OC_EMPTY;
              done        = 1'b1;
            end else begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        outcome_nxt = spq_pkg::OC_DEQUEUED;
        otag_nxt    = mem_rdata[TAG_BITS-1:0];
        oprio_nxt   = rd_prio;
        head_nxt    = (head_r == LAST_I) ? '0 : head_r + IDX_W'(1);
        count_nxt   = count_r - CNT_W'(1);
        done        = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_WALK: begin
        mem_we = 1'b1;
        if (rd_prio > new_prio_r) begin
          mem_wdata = mem_rdata;
          if (cur_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            cur_nxt = cur_r - IDX_W'(1);
          end
        end else begin
          count_nxt   = count_r + CNT_W'(1);
          outcome_nxt = spq_pkg::OC_SUBMITTED;
          done        = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_PLACE: begin
        mem_we      = 1'b1;
        mem_waddr   = head_r;
        count_nxt   = count_r + CNT_W'(1);
        outcome_nxt = spq_pkg::OC_SUBMITTED;
        done        = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    occ_nxt       = done ? spq_pkg::OCC_W'(count_nxt) : occ_r;
    out_valid_nxt = done ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    new_tag_r  <= new_tag_nxt;
    new_prio_r <= new_prio_nxt;
    outcome_r  <= outcome_nxt;
    otag_r     <= otag_nxt;
    oprio_r    <= oprio_nxt;
    occ_r      <= occ_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = outcome_r;
  assign out_tag     = otag_r;
  assign out_prio    = oprio_r;
  assign out_occ     = occ_r;

endmodule

// File: hdl/stable_priority_task_queue.sv
// Drop, empty run and submit to an empty queue are answered from the idle state;
// a run reads the head entry in the run state; a submit to a non-empty queue walks
// from the tail, shifting each stored entry of lower urgency toward the tail.
// One request at a time: a new request is taken only in idle with the result slot free.
// Reset clears count, head pointer and result valid; stored entries are not cleared.
`timescale 1ns / 1ps
module stable_priority_task_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF,
  localparam int IN_W  = ((1 + TAG_BITS + spq_pkg::PRIO_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 + TAG_BITS + spq_pkg::PRIO_W + spq_pkg::OCC_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // command, task_tag, priority_req
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // outcome, out_tag, out_priority, occupancy
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int ENT_W = TAG_BITS + spq_pkg::PRIO_W;

  logic                       in_cmd;
  logic [TAG_BITS-1:0]        in_tag;
  logic [spq_pkg::PRIO_W-1:0] in_prio;
  spq_pkg::outcome_t          res_outcome;
  logic [TAG_BITS-1:0]        res_tag;
  logic [spq_pkg::PRIO_W-1:0] res_prio;
  logic [spq_pkg::OCC_W-1:0]  res_occ;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  logic [ENT_W-1:0]           mem_wdata;
  logic [IDX_W-1:0]           mem_raddr;
  logic [ENT_W-1:0]           mem_rdata;

  assign in_cmd  = in_tdata[0];
  assign in_tag  = in_tdata[TAG_BITS:1];
  assign in_prio = in_tdata[TAG_BITS + spq_pkg::PRIO_W -: spq_pkg::PRIO_W];

  assign out_tdata = OUT_W'({res_occ, res_prio, res_tag, res_outcome});

  spq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_cmd),
    .in_tag      (in_tag),
    .in_prio     (in_prio),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_outcome (res_outcome),
    .out_tag     (res_tag),
    .out_prio    (res_prio),
    .out_occ     (res_occ),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench for the stable priority task queue stream block.
`timescale 1ns / 1ps
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 300;

  typedef enum logic {
    CMD_SUBMIT = 1'b0,
    CMD_RUN    = 1'b1
  } command_t;

  typedef struct {
    logic [spq_pkg::TAG_BITS_DEF-1:0] tag;
    logic [spq_pkg::PRIO_W-1:0]       prio;
  } task_entry_t;

  typedef struct {
    spq_pkg::outcome_t                outcome;
    logic [spq_pkg::TAG_BITS_DEF-1:0] tag;
    logic [spq_pkg::PRIO_W-1:0]       prio;
    logic [spq_pkg::OCC_W-1:0]        occ;
  } task_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // command, task_tag, priority_req, zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // outcome, out_tag, out_priority, occupancy, zero pad

  task_entry_t  held_tasks[$];
  task_result_t pending_outcomes[$];
  int           err_count = 0;
  int           hold_cycles = 0;
  bit           idle_on = 1'b1;
  int           quiet_cycles = 0;

  stable_priority_task_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic task_result_t predict_result(command_t cmd, logic [15:0] tag,
                                                  logic [2:0] prio_in);
    task_entry_t  ent;
    task_result_t r;
    int           pos;
    logic [2:0]   prio;
    prio = (prio_in > spq_pkg::MAX_PRIORITY) ? spq_pkg::MAX_PRIORITY : prio_in;
    r.outcome = spq_pkg::OC_SUBMITTED;
    r.tag = '0;
    r.prio = '0;
    if (cmd == CMD_SUBMIT) begin
      if (held_tasks.size() >= spq_pkg::QUEUE_DEPTH_DEF) begin
        r.outcome = spq_pkg::OC_DROPPED;
      end else begin
        pos = 0;
        while (pos < held_tasks.size() && held_tasks[pos].prio <= prio) pos++;
        ent.tag = tag;
        ent.prio = prio;
        held_tasks.insert(pos, ent);
      end
    end else if (held_tasks.size() == 0) begin
      r.outcome = spq_pkg::OC_EMPTY;
    end else begin
      ent = held_tasks.pop_front();
      r.outcome = spq_pkg::OC_DEQUEUED;
      r.tag = ent.tag;
      r.prio = ent.prio;
    end
    r.occ = spq_pkg::OCC_W'(held_tasks.size());
    return r;
  endfunction

  task automatic send_request(command_t cmd, logic [15:0] tag, logic [2:0] prio);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, prio, tag, cmd};
    do @(posedge clk); while (!in_tready);
    pending_outcomes.push_back(predict_result(cmd, tag, prio));
  endtask

  task automatic check_result(logic [31:0] d);
    task_result_t exp_r;
    if (pending_outcomes.size() == 0) begin
      $error("unexpected result: tdata %h", d);
      err_count++;
    end else begin
      exp_r = pending_outcomes.pop_front();
      if (d[1:0] !== exp_r.outcome) begin
        $error("outcome mismatch: expected %0d, got %0d", exp_r.outcome, d[1:0]);
        err_count++;
      end
      if (d[17:2] !== exp_r.tag) begin
        $error("out_tag mismatch: expected %h, got %h", exp_r.tag, d[17:2]);
        err_count++;
      end
      if (d[20:18] !== exp_r.prio) begin
        $error("out_priority mismatch: expected %0d, got %0d", exp_r.prio, d[20:18]);
        err_count++;
      end
      if (d[25:21] !== exp_r.occ) begin
        $error("occupancy mismatch: expected %0d, got %0d", exp_r.occ, d[25:21]);
        err_count++;
      end
    end
  endtask

  task automatic wait_drained();
    wait (pending_outcomes.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_and_order();
    send_request(CMD_RUN, 16'hFFFF, 3'd7);
    send_request(CMD_SUBMIT, 16'h0000, 3'd7);
    send_request(CMD_SUBMIT, 16'hFFFF, 3'd6);
    send_request(CMD_SUBMIT, 16'h1234, 3'd5);
    send_request(CMD_SUBMIT, 16'hA5A5, 3'd0);
    send_request(CMD_SUBMIT, 16'h5A5A, 3'd3);
    send_request(CMD_SUBMIT, 16'h0001, 3'd0);
    send_request(CMD_SUBMIT, 16'h8000, 3'd4);
    repeat (7) send_request(CMD_RUN, 16'h0000, 3'd0);
    send_request(CMD_RUN, 16'h0000, 3'd0);
  endtask

  task automatic test_full_queue();
    repeat (spq_pkg::QUEUE_DEPTH_DEF) send_request(CMD_SUBMIT, 16'($urandom), 3'($urandom));
    send_request(CMD_SUBMIT, 16'hFFFF, 3'd0);
    send_request(CMD_SUBMIT, 16'h0000, 3'd7);
    repeat (spq_pkg::QUEUE_DEPTH_DEF + 1) begin
      send_request(CMD_RUN, 16'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (24) begin
      send_request($urandom_range(0, 2) == 0 ? CMD_RUN : CMD_SUBMIT,
                   16'($urandom), 3'($urandom_range(0, 5)));
    end
    in_tvalid <= 1'b0;
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned submit_pct;
    int unsigned prio_lo;
    int unsigned prio_hi;
    command_t    cmd;
    logic [2:0]  prio;
    repeat (16) begin
      case ($urandom_range(0, 3))
        0: submit_pct = 25;
        1: submit_pct = 50;
        2: submit_pct = 75;
        default: submit_pct = 90;
      endcase
      prio_lo = $urandom_range(0, 5);
      prio_hi = ($urandom_range(0, 1) == 0) ? prio_lo + $urandom_range(0, 1) : 7;
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (50) begin
        cmd = ($urandom_range(1, 100) <= submit_pct) ? CMD_SUBMIT : CMD_RUN;
        prio = 3'($urandom_range(prio_lo, prio_hi));
        send_request(cmd, 16'($urandom), prio);
      end
      if ($urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_order();
    test_full_queue();
    test_backpressure();
    test_random_traffic();
    in_tvalid <= 1'b0;
    wait (pending_outcomes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/spq_ctrl.sv
hdl/stable_priority_task_queue.sv
dv/tb.sv
